// ----- design/sfct_pkg.sv -----
// shared types and constants of the source flood counter table
`timescale 1ns / 1ps

package sfct_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int OCC_W       = $clog2(TABLE_DEPTH + 1);

  localparam int ADDR_W      = 32;
  localparam int COUNT_W     = 32;
  localparam int FRAME_W     = 16;
  localparam int HALF_TIME_W = 6;
  localparam int TIME_W      = 2 * HALF_TIME_W;
  localparam int ENTRY_IDX_W = 5;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 96;
  localparam int OUT_TUSER_W = 2;

  typedef enum logic {
    FUNC_ACCUM = 1'b0,
    FUNC_DUMP  = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HIT,
    ST_MISS,
    ST_DUMP_RD,
    ST_DUMP_EMIT
  } state_e;

  typedef struct packed {
    logic [ADDR_W-1:0]  key;
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  first_time;
    logic [TIME_W-1:0]  latest_time;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic overflow;
    logic hit;
  } out_flags_t;

endpackage

// ----- design/sfct_table.sv -----
// entry memory: one write port, one read port with registered read data
`timescale 1ns / 1ps

module sfct_table import sfct_pkg::*; (
  input  logic     clk_i,
  input  mem_req_t req_i,
  output entry_t   rdata_o
);

  entry_t mem_q [TABLE_DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/sfct_alu.sv -----
// shared key compare and saturating count adder
`timescale 1ns / 1ps

module sfct_alu import sfct_pkg::*; (
  input  logic [ADDR_W-1:0]  key_a_i,
  input  logic [ADDR_W-1:0]  key_b_i,
  input  logic [COUNT_W-1:0] count_i,
  input  logic [FRAME_W-1:0] frames_i,
  output logic               key_eq_o,
  output logic [COUNT_W-1:0] sum_o
);

  logic [COUNT_W:0] wide_sum;

  assign key_eq_o = (key_a_i == key_b_i);
  assign wide_sum = {1'b0, count_i} + {{(COUNT_W + 1 - FRAME_W){1'b0}}, frames_i};
  // carry out means the 32-bit total wrapped: clamp to all ones
  assign sum_o    = wide_sum[COUNT_W] ? {COUNT_W{1'b1}} : wide_sum[COUNT_W-1:0];

endmodule

// ----- design/source_flood_counter_table.sv -----
// top level of the per-source frame counter table
`timescale 1ns / 1ps

// Per-source frame counter table. Each input transfer either accumulates a
// record (tuser = 0) or dumps the table (tuser = 1). An accumulate searches
// the occupied entries in position order through the single read port of the
// entry memory, one entry issued per cycle with the key compare in the cycle
// after the read. Its one result is loaded into the output register. A hit
// adds the frame count with saturation at 32 bits and refreshes the latest
// time; a miss appends a new entry. When an append fills the table the
// occupancy wraps to zero and the result carries the overflow flag; older
// entries are then no longer searched or dumped and get overwritten from
// position zero. A dump sends one result per occupied entry, reading each
// entry before it is sent, with tlast on the final one, and then clears the
// occupancy; an empty dump sends nothing. Only one item is in work at a
// time: s_axis_tready is high while the sequencer is idle, which includes
// the time a finished result still waits in the output register. The entry
// memory has no reset; an entry is only read after it has been written.
module source_flood_counter_table import sfct_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [31:0] src_addr, [47:32] frame_count, [53:48] minute, [59:54] second
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] func
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [31:0] entry_addr, [63:32] total_count, [69:64] first_minute,
  // [75:70] first_second, [81:76] latest_minute, [87:82] latest_second,
  // [92:88] entry_index
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // [0] hit, [1] overflow
  output logic [OUT_TUSER_W-1:0] m_axis_tuser,
  output logic                   m_axis_tlast
);

  // sequencer state
  state_e             state_q, state_d;
  logic [OCC_W-1:0]   occ_q, occ_d;
  logic [OCC_W-1:0]   rd_ptr_q, rd_ptr_d;     // next entry to read
  logic [OCC_W-1:0]   cmp_ptr_q, cmp_ptr_d;   // entry held in the read register
  logic               cmp_valid_q, cmp_valid_d;

  // captured item
  logic [ADDR_W-1:0]  item_addr_q;
  logic [FRAME_W-1:0] item_frames_q;
  logic [TIME_W-1:0]  item_time_q;

  // output register
  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;
  out_flags_t             out_flags_q;
  logic                   out_last_q;

  // next result
  logic               emit;
  logic [ADDR_W-1:0]  res_addr;
  logic [COUNT_W-1:0] res_count;
  logic [TIME_W-1:0]  res_first;
  logic [TIME_W-1:0]  res_latest;
  logic [OCC_W-1:0]   res_pos;
  out_flags_t         res_flags;
  logic               res_last;

  logic               in_xfer;
  logic               out_free;
  logic               key_eq;
  logic               match;
  logic [COUNT_W-1:0] sat_sum;
  logic [OCC_W-1:0]   occ_inc;
  logic [OCC_W-1:0]   rd_ptr_inc;
  logic               table_full;
  mem_req_t           mem_req;
  entry_t             rd_entry;

  assign in_xfer    = s_axis_tvalid && s_axis_tready;
  assign out_free   = !out_valid_q || m_axis_tready;
  assign occ_inc    = occ_q + OCC_W'(1);
  assign rd_ptr_inc = rd_ptr_q + OCC_W'(1);
  assign table_full = (occ_inc == OCC_W'(TABLE_DEPTH));
  assign match      = cmp_valid_q && key_eq;

  sfct_table u_table (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rd_entry)
  );

  sfct_alu u_alu (
    .key_a_i  (rd_entry.key),
    .key_b_i  (item_addr_q),
    .count_i  (rd_entry.count),
    .frames_i (item_frames_q),
    .key_eq_o (key_eq),
    .sum_o    (sat_sum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      occ_q       <= '0;
      rd_ptr_q    <= '0;
      cmp_ptr_q   <= '0;
      cmp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      rd_ptr_q    <= rd_ptr_d;
      cmp_ptr_q   <= cmp_ptr_d;
      cmp_valid_q <= cmp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_addr_q   <= s_axis_tdata[31:0];
      item_frames_q <= s_axis_tdata[47:32];
      item_time_q   <= {s_axis_tdata[53:48], s_axis_tdata[59:54]};
    end
  end

  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    rd_ptr_d    = rd_ptr_q;
    cmp_ptr_d   = cmp_ptr_q;
    cmp_valid_d = cmp_valid_q;

    s_axis_tready = 1'b0;
    mem_req       = '0;
    emit          = 1'b0;
    res_addr      = rd_entry.key;
    res_count     = rd_entry.count;
    res_first     = rd_entry.first_time;
    res_latest    = rd_entry.latest_time;
    res_pos       = rd_ptr_q;
    res_flags     = '0;
    res_last      = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          rd_ptr_d    = '0;
          cmp_valid_d = 1'b0;
          if (func_e'(s_axis_tuser) == FUNC_DUMP) begin
            // an empty dump sends nothing
            if (occ_q != '0) begin
              state_d = ST_DUMP_RD;
            end
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (match) begin
          // hold the read register: it feeds the update
          state_d = ST_HIT;
        end else if (rd_ptr_q == occ_q) begin
          state_d = ST_MISS;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = rd_ptr_q[IDX_W-1:0];
          cmp_ptr_d     = rd_ptr_q;
          cmp_valid_d   = 1'b1;
          rd_ptr_d      = rd_ptr_inc;
        end
      end

      ST_HIT: begin
        res_count      = sat_sum;
        res_latest     = item_time_q;
        res_pos        = cmp_ptr_q;
        res_flags.hit  = 1'b1;
        if (out_free) begin
          emit                      = 1'b1;
          mem_req.we                = 1'b1;
          mem_req.waddr             = cmp_ptr_q[IDX_W-1:0];
          mem_req.wdata.key         = rd_entry.key;
          mem_req.wdata.count       = sat_sum;
          mem_req.wdata.first_time  = rd_entry.first_time;
          mem_req.wdata.latest_time = item_time_q;
          state_d                   = ST_IDLE;
        end
      end

      ST_MISS: begin
        res_addr           = item_addr_q;
        res_count          = {{(COUNT_W - FRAME_W){1'b0}}, item_frames_q};
        res_first          = item_time_q;
        res_latest         = item_time_q;
        res_pos            = occ_q;
        res_flags.overflow = table_full;
        if (out_free) begin
          emit                      = 1'b1;
          mem_req.we                = 1'b1;
          mem_req.waddr             = occ_q[IDX_W-1:0];
          mem_req.wdata.key         = item_addr_q;
          mem_req.wdata.count       = res_count;
          mem_req.wdata.first_time  = item_time_q;
          mem_req.wdata.latest_time = item_time_q;
          occ_d                     = table_full ? '0 : occ_inc;
          state_d                   = ST_IDLE;
        end
      end

      ST_DUMP_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = rd_ptr_q[IDX_W-1:0];
        state_d       = ST_DUMP_EMIT;
      end

      ST_DUMP_EMIT: begin
        res_last = (rd_ptr_inc == occ_q);
        if (out_free) begin
          emit = 1'b1;
          if (res_last) begin
            occ_d   = '0;
            state_d = ST_IDLE;
          end else begin
            rd_ptr_d = rd_ptr_inc;
            state_d  = ST_DUMP_RD;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register: a result waits here while the next item is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q  <= {3'b000, ENTRY_IDX_W'(res_pos),
                      res_latest[HALF_TIME_W-1:0], res_latest[TIME_W-1:HALF_TIME_W],
                      res_first[HALF_TIME_W-1:0], res_first[TIME_W-1:HALF_TIME_W],
                      res_count, res_addr};
      out_flags_q <= res_flags;
      out_last_q  <= res_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_flags_q;
  assign m_axis_tlast  = out_last_q;

  // occupancy never reaches the depth: it wraps on the filling insert
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q < OCC_W'(TABLE_DEPTH))
    else $error("occupancy reached table depth");

  // the search never reads past the occupied entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (rd_ptr_q <= occ_q))
    else $error("search pointer beyond occupancy");

  // a hit always reports an occupied position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && state_q == ST_HIT) |-> (cmp_ptr_q < occ_q))
    else $error("hit outside occupied entries");

  // the final dump transfer empties the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && state_q == ST_DUMP_EMIT && res_last) |=> (occ_q == '0))
    else $error("dump did not clear occupancy");

endmodule
